[rtl/core/activation_function_unit_core_assert.svh]
// assertion macros for the activation function unit
`ifndef ACTIVATION_FUNCTION_UNIT_CORE_ASSERT_SVH
`define ACTIVATION_FUNCTION_UNIT_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AFU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("afu assertion failed");

// next-cycle implication, checked outside reset
`define AFU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("afu assertion failed");

`endif

[rtl/core/afu_pkg.sv]
// shared constants, types and rom tables of the activation function unit
`timescale 1ns / 1ps
package afu_pkg;

    localparam int DATA_W = 16;
    localparam int ARG_W  = 24;

    localparam logic [2:0] MODE_RELU  = 3'd0;
    localparam logic [2:0] MODE_SILU  = 3'd1;
    localparam logic [2:0] MODE_GELU  = 3'd2;
    localparam logic [2:0] MODE_SWISH = 3'd3;
    localparam logic [2:0] MODE_GATED = 3'd4;

    localparam logic [2:0] ADDR_MODE = 3'd0;
    localparam logic [2:0] ADDR_BETA = 3'd4;

    localparam logic signed [DATA_W-1:0] BETA_RESET = 16'sd1024;

    typedef struct packed {
        logic                     valid;
        logic [2:0]               mode;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] up;
    } t_ctl;

    typedef logic [255:0][16:0] t_rom;

    // restoring long division, evaluated only while building the tables
    function automatic longint unsigned udiv(input longint unsigned a,
                                             input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        int              j;
        q = '0;
        r = '0;
        for (j = 63; j >= 0; j--) begin
            r = {r[62:0], a[j]};
            if (r >= b) begin
                r    = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_rom build_rom(input logic tanh_sel);
        t_rom              rom;
        longint unsigned   ex [257];
        longint            sum;
        longint            term;
        longint unsigned   base;
        longint unsigned   d;
        longint unsigned   p;
        longint unsigned   d2;
        longint unsigned   n2;
        longint unsigned   t;
        longint            v;
        int                n;
        int                i;
        int                m;
        int                k;
        sum  = 64'sd1 <<< 62;
        term = 64'sd1 <<< 62;
        for (n = 1; n < 40; n++) begin
            if (term != 0) begin
                term = longint'(udiv(unsigned'(term), 64'(16 * n)));
                if (n[0]) sum = sum - term;
                else sum = sum + term;
            end
        end
        base  = (longint'(unsigned'(sum)) + (64'd1 << 30)) >> 31;
        ex[0] = 64'd1 << 31;
        for (i = 1; i <= 256; i++) begin
            ex[i] = (ex[i-1] * base + (64'd1 << 30)) >> 31;
        end
        for (i = 0; i < 256; i++) begin
            m  = i - 128;
            k  = (m < 0) ? -m : m;
            d  = (64'd1 << 31) + ex[k];
            p  = udiv((64'd1 << 46) + (d >> 1), d);
            d2 = (64'd1 << 31) + ex[2*k];
            n2 = (64'd1 << 31) - ex[2*k];
            t  = udiv((n2 << 15) + (d2 >> 1), d2);
            if (tanh_sel) v = (m >= 0) ? longint'(t) : -longint'(t);
            else v = (m >= 0) ? longint'(p) : 64'sd32768 - longint'(p);
            rom[i] = v[16:0];
        end
        return rom;
    endfunction

    localparam t_rom SIG_ROM  = build_rom(1'b0);
    localparam t_rom TANH_ROM = build_rom(1'b1);

endpackage

[rtl/core/afu_if.sv]
// item channel interfaces of the activation function unit
`timescale 1ns / 1ps
interface afu_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_value;
    logic signed [15:0] up_value;
    modport source (output valid, x_value, up_value, input ready);
    modport sink (input valid, x_value, up_value, output ready);
endinterface

interface afu_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] y_value;
    logic               saturated;
    modport source (output valid, y_value, saturated, input ready);
    modport sink (input valid, y_value, saturated, output ready);
endinterface

[rtl/core/afu_arg.sv]
// table argument stages: gelu cubic polynomial and swish scaling; other modes pass x on
`timescale 1ns / 1ps
module afu_arg import afu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_ctl                     i_ctl,
    input  logic signed [DATA_W-1:0] i_beta,
    output t_ctl                     o_ctl,
    output logic signed [ARG_W-1:0]  o_arg
);

    localparam logic signed [15:0] LIM  = 16'sd8192;
    localparam logic signed [16:0] C3   = 17'sd46887;
    localparam logic signed [20:0] C1   = 21'sd836643;
    localparam logic signed [31:0] H10  = 32'sd512;
    localparam logic signed [39:0] H20  = 40'sd524288;

    t_ctl                    r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic signed [15:0]      r_u1, r_u2;
    logic signed [17:0]      r_x2;
    logic signed [20:0]      r_x3;
    logic signed [17:0]      r_inner;
    logic signed [ARG_W-1:0] r_sw1, r_sw2, r_sw3;
    logic signed [ARG_W-1:0] r_arg;

    logic signed [15:0]      n_u;
    logic signed [31:0]      p_uu;
    logic signed [31:0]      p_sw;
    logic signed [33:0]      p_x3;
    logic signed [37:0]      p_c3;
    logic signed [39:0]      p_c1;
    logic signed [17:0]      n_inner;
    logic signed [ARG_W-1:0] n_arg;

    always_comb begin
        if (i_ctl.x > LIM) begin
            n_u = LIM;
        end else if (i_ctl.x < -LIM) begin
            n_u = -LIM;
        end else begin
            n_u = i_ctl.x;
        end
        p_uu    = n_u * n_u + H10;
        p_sw    = i_beta * i_ctl.x + H10;
        p_x3    = r_x2 * r_u1 + 34'sd512;
        p_c3    = C3 * r_x3 + 38'sd524288;
        n_inner = $signed(p_c3[37:20]) + r_u2;
        p_c1    = C1 * r_inner + H20;
        case (r_ctl3.mode)
            MODE_GELU:  n_arg = ARG_W'($signed(p_c1[39:20]));
            MODE_SWISH: n_arg = r_sw3;
            default:    n_arg = ARG_W'(r_ctl3.x);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1    <= n_u;
            r_x2    <= $signed(p_uu[27:10]);
            r_sw1   <= ARG_W'($signed(p_sw[31:10]));
            r_u2    <= r_u1;
            r_x3    <= $signed(p_x3[30:10]);
            r_sw2   <= r_sw1;
            r_inner <= n_inner;
            r_sw3   <= r_sw2;
            r_arg   <= n_arg;
        end
    end

    assign o_ctl = r_ctl4;
    assign o_arg = r_arg;

endmodule

[rtl/core/afu_lut.sv]
// sigmoid and tanh table lookup with linear interpolation
`timescale 1ns / 1ps
module afu_lut import afu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_ctl                    i_ctl,
    input  logic signed [ARG_W-1:0] i_arg,
    output t_ctl                    o_ctl,
    output logic signed [17:0]      o_s
);

    localparam logic signed [ARG_W-1:0] SPAN = 24'sd8192;
    localparam logic signed [16:0]      ONE  = 17'sd32768;

    t_ctl               r_ctl1, r_ctl2;
    logic signed [16:0] r_e0;
    logic signed [17:0] r_d;
    logic [5:0]         r_fr;
    logic signed [17:0] r_s;

    logic [ARG_W-1:0]   ua;
    logic [7:0]         idx;
    logic [7:0]         idx1;
    logic               tanh_sel;
    logic signed [16:0] e0;
    logic signed [16:0] e1;
    logic signed [16:0] n_e0;
    logic signed [17:0] n_d;
    logic signed [24:0] p_fr;

    always_comb begin
        ua       = i_arg + SPAN;
        idx      = ua[13:6];
        idx1     = 8'(idx + 8'd1);
        tanh_sel = (i_ctl.mode == MODE_GELU);
        e0       = tanh_sel ? $signed(TANH_ROM[idx]) : $signed(SIG_ROM[idx]);
        if (idx == 8'd255) begin
            e1 = ONE;
        end else begin
            e1 = tanh_sel ? $signed(TANH_ROM[idx1]) : $signed(SIG_ROM[idx1]);
        end
        if (i_arg < -SPAN) begin
            n_e0 = tanh_sel ? -ONE : 17'sd0;
            n_d  = 18'sd0;
        end else if (i_arg >= SPAN) begin
            n_e0 = ONE;
            n_d  = 18'sd0;
        end else begin
            n_e0 = e0;
            n_d  = e1 - e0;
        end
        p_fr = r_d * $signed({1'b0, r_fr}) + 25'sd32;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e0 <= n_e0;
            r_d  <= n_d;
            r_fr <= ua[5:0];
            r_s  <= 18'(r_e0 + $signed(p_fr[24:6]));
        end
    end

    assign o_ctl = r_ctl2;
    assign o_s   = r_s;

endmodule

[rtl/core/afu_post.sv]
// output multiply, gating, rounding and saturation stages
`timescale 1ns / 1ps
module afu_post import afu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_ctl                     i_ctl,
    input  logic signed [17:0]       i_s,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_y,
    output logic                     o_sat
);

    localparam logic signed [24:0] MAXV = 25'sd32767;
    localparam logic signed [24:0] MINV = -25'sd32768;

    t_ctl                     r_ctl1;
    logic                     r_valid2, r_valid3;
    logic signed [18:0]       r_y1;
    logic signed [24:0]       r_z;
    logic signed [DATA_W-1:0] r_y;
    logic                     r_sat;

    logic signed [18:0] w;
    logic signed [34:0] p_g;
    logic signed [33:0] p_s;
    logic signed [34:0] p_up;
    logic signed [18:0] n_y1;
    logic signed [24:0] n_z;
    logic signed [DATA_W-1:0] n_y;
    logic               n_sat;

    always_comb begin
        w   = 19'sd32768 + i_s;
        p_g = i_ctl.x * w + 35'sd32768;
        p_s = i_ctl.x * i_s + 34'sd16384;
        case (i_ctl.mode)
            MODE_RELU:  n_y1 = i_ctl.x[15] ? 19'sd0 : 19'(i_ctl.x);
            MODE_GELU:  n_y1 = $signed(p_g[34:16]);
            MODE_SILU,
            MODE_SWISH,
            MODE_GATED: n_y1 = $signed(p_s[33:15]);
            default:    n_y1 = 19'(i_ctl.x);
        endcase
        p_up = r_y1 * r_ctl1.up + 35'sd512;
        if (r_ctl1.mode == MODE_GATED) begin
            n_z = $signed(p_up[34:10]);
        end else begin
            n_z = 25'(r_y1);
        end
        if (r_z > MAXV) begin
            n_y   = 16'sh7fff;
            n_sat = 1'b1;
        end else if (r_z < MINV) begin
            n_y   = -16'sh8000;
            n_sat = 1'b1;
        end else begin
            n_y   = r_z[15:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1   <= '0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_en) begin
            r_ctl1   <= i_ctl;
            r_valid2 <= r_ctl1.valid;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y1  <= n_y1;
            r_z   <= n_z;
            r_y   <= n_y;
            r_sat <= n_sat;
        end
    end

    assign o_valid = r_valid3;
    assign o_y     = r_y;
    assign o_sat   = r_sat;

endmodule

[rtl/core/activation_function_unit_core.sv]
// top level of the activation function unit
// usage:
//   i_in carries one item per handshake: x_value and up_value, signed q5.10
//   o_out returns one item per input item: y_value (q5.10) and saturated
//   the apb port writes activation_mode at 0x0 and swish_beta at 0x4
//   write the registers only while no item is in flight
// pipeline and throughput:
//   nine register stages between an accepted input item and its result
//   one item per cycle unless the output stalls; the stage count is set
//   by the chain of gelu multiplies, the table lookup and interpolation,
//   and the gating multiply
// reset:
//   synchronous, active low; all stage valid bits clear, mode goes to relu
//   and swish_beta to 1.0
// stall:
//   when o_out.ready is low with a result held, the whole pipeline holds
//   and i_in.ready drops; nothing is lost or repeated
`timescale 1ns / 1ps
`include "activation_function_unit_core_assert.svh"
module activation_function_unit_core import afu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    afu_in_if.sink      i_in,
    afu_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]               r_mode;
    logic signed [DATA_W-1:0] r_beta;

    logic                    en;
    logic                    wr;
    t_ctl                    in_ctl;
    t_ctl                    arg_ctl;
    t_ctl                    lut_ctl;
    logic signed [ARG_W-1:0] arg;
    logic signed [17:0]      s_val;
    logic                    post_valid;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RELU;
            r_beta <= BETA_RESET;
        end else if (wr) begin
            if (paddr == ADDR_MODE) r_mode <= pwdata[2:0];
            if (paddr == ADDR_BETA) r_beta <= pwdata[15:0];
        end
    end

    always_comb begin
        case (paddr)
            ADDR_MODE: prdata = {29'd0, r_mode};
            ADDR_BETA: prdata = {16'd0, r_beta};
            default:   prdata = 32'd0;
        endcase
    end

    assign en         = !post_valid || o_out.ready;
    assign i_in.ready = en;

    assign in_ctl.valid = i_in.valid;
    assign in_ctl.mode  = r_mode;
    assign in_ctl.x     = i_in.x_value;
    assign in_ctl.up    = i_in.up_value;

    afu_arg u_arg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (in_ctl),
        .i_beta  (r_beta),
        .o_ctl   (arg_ctl),
        .o_arg   (arg)
    );

    afu_lut u_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (arg_ctl),
        .i_arg   (arg),
        .o_ctl   (lut_ctl),
        .o_s     (s_val)
    );

    afu_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (lut_ctl),
        .i_s     (s_val),
        .o_valid (post_valid),
        .o_y     (o_out.y_value),
        .o_sat   (o_out.saturated)
    );

    assign o_out.valid = post_valid;

    `AFU_ASSERT_IMPL(a_sat_at_limit, o_out.valid && o_out.saturated,
        o_out.y_value == 16'sh7fff || o_out.y_value == -16'sh8000)
    `AFU_ASSERT_IMPL(a_ready_follows_out, 1'b1,
        i_in.ready == (!o_out.valid || o_out.ready))
    `AFU_ASSERT_NEXT(a_relu_nonneg, o_out.valid && o_out.ready && r_mode == MODE_RELU
        && $stable(r_mode) && !wr,
        !o_out.valid || r_mode != MODE_RELU || (!o_out.saturated && !o_out.y_value[15]))

endmodule
